@@ design/ddo_pkg.sv @@
// ddo_pkg: shared types, constants and the arctangent table for the
// differential-drive odometry block. No dependencies.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int MAX_ROT          = 24;

  localparam logic [15:0]        RADIUS_RST   = 16'd6881;
  localparam logic [19:0]        TRACK_RST    = 20'd34734;
  localparam logic [29:0]        TURN_SCALE   = 30'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [19:0]        USEC_PER_SEC = 20'd1000000;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_TRACK  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_op_t;

  typedef struct packed {
    logic   start;
    md_op_t op;
  } md_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DS, S_NUM, S_DTH, S_DBAM, S_HBAM, S_CS, S_PX, S_PY,
    S_LVM, S_LVD, S_AVM, S_AVD, S_QUAT, S_OUT
  } state_t;

  // atan(2^-i) as a binary angle, 2^32 = one turn
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

@@ design/diff_drive_odometry.sv @@
// diff_drive_odometry: differential-drive wheel odometry, top level.
// Depends on ddo_pkg, ddo_muldiv and ddo_cordic.
//
// Use:
//   One input transaction per wheel tick on the s_ channel carries both wheel
//   angles, their valid flags and the elapsed time. One output transaction on
//   the m_ channel returns the pose (x, y, yaw), the half-yaw quaternion z/w,
//   the linear and angular speed and the zero-time flag.
//   The wheel radius (address 0) and wheel_track (address 4) read back over APB;
//   write them only when no tick is in flight (the block does not check).
// Throughput:
//   One tick at a time; s_tready is high only when the sequencer is idle.
//   All arithmetic runs through one bit-serial multiply/divide unit (one bit
//   per cycle, divides take 66 steps) plus one CORDIC unit (CORDIC_STEPS
//   rotations, run twice per tick, once when elapsed_us is zero). Multiplies
//   stop early on short multipliers.
// Reset: clears pose, heading, stored angles and flags, restores register
//   defaults and empties the output register.
// Stall: a finished result sits in the output register until m_tready; the
//   sequencer holds its last step until that register is free.
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // tick input
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [87:0]  s_tdata,   // left_angle, right_angle, elapsed_us
  input  logic [1:0]   s_tuser,   // left_ok, right_ok
  // pose output
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // pos_x, pos_y, yaw_angle, quat_z, quat_w,
                                  // lin_vel, ang_vel
  output logic [0:0]   m_tuser    // zero_time
);
  import ddo_pkg::*;

  // configuration
  logic [15:0] radius;
  logic [19:0] wheel_track;
  logic [19:0] track_eff;

  // persistent state
  state_t      state, state_next;
  logic [31:0] prev_left, prev_right;
  logic        prev_left_bad, prev_right_bad;
  logic signed [31:0] acc_x, acc_y;
  logic [31:0] heading;

  // per-tick working registers
  logic signed [33:0] sum, diff;
  logic [23:0]        dt;
  logic               zero;
  logic signed [34:0] ds;
  logic [63:0]        t32;
  logic [49:0]        dthq;
  logic [31:0]        dbam;
  logic signed [31:0] lv, av;
  logic signed [15:0] qz, qw;

  // shared units
  md_ctl_t            md_ctl;
  logic [65:0]        md_a, md_result;
  logic [33:0]        md_b;
  logic               md_done;
  logic               cs_start, cs_done;
  logic [31:0]        cs_angle;
  logic signed [33:0] cos_val, sin_val;

  // input fields
  logic [31:0]        cl, cr;
  logic [23:0]        dt_in;
  logic               lok, rok, accept;
  logic signed [32:0] dl_in, dr_in;
  logic signed [33:0] sum_in, diff_in;
  logic [33:0]        sum_mag_in, diff_mag;

  // datapath helpers
  logic signed [63:0] ds_prod, ds_rnd;
  logic [63:0]        t32_c;
  logic signed [34:0] dsc;
  logic [32:0]        dsc_mag;
  logic [34:0]        ds_mag;
  logic [33:0]        cos_mag, sin_mag;
  logic signed [33:0] trig;
  logic signed [63:0] pos_prod;
  logic signed [33:0] pos_rnd;
  logic signed [31:0] acc_sel;
  logic signed [35:0] acc_sum;
  logic signed [31:0] acc_new;
  logic               dth_big;
  logic               wr_en;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -36'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7FFF;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // quotient q of |v|*1e6/dt back to a signed, saturated rate
  function automatic logic signed [31:0] rate_of(input logic neg,
                                                 input logic [65:0] q);
    if (q[65:31] != '0) return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    return neg ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

  function automatic logic signed [15:0] q15_of(input logic signed [33:0] v);
    logic signed [34:0] t;
    t = {v[33], v} + 35'sd16384;
    return sat16(20'(t >>> 15));
  endfunction

  //--------------------------------------------------------------------------
  // Configuration port: writes complete in the access phase
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RST;
      wheel_track <= TRACK_RST;
    end else if (wr_en) begin
      case (reg_idx_t'(paddr[2]))
        REG_RADIUS: radius      <= pwdata[15:0];
        REG_TRACK:  wheel_track <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_RADIUS: prdata = {16'h0, radius};
      REG_TRACK:  prdata = {12'h0, wheel_track};
      default:    prdata = '0;
    endcase
  end

  // a zero track divides by one
  assign track_eff = (wheel_track == '0) ? 20'd1 : wheel_track;

  //--------------------------------------------------------------------------
  // Wheel deltas from the incoming tick
  //--------------------------------------------------------------------------
  assign cl       = s_tdata[31:0];
  assign cr       = s_tdata[63:32];
  assign dt_in    = s_tdata[87:64];
  assign lok      = s_tuser[0];
  assign rok      = s_tuser[1];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    // a wheel that is invalid now, or was on the last tick, contributes no travel
    dl_in = (lok && !prev_left_bad) ?
            $signed({cl[31], cl}) - $signed({prev_left[31], prev_left}) : '0;
    dr_in = (rok && !prev_right_bad) ?
            $signed({cr[31], cr}) - $signed({prev_right[31], prev_right}) : '0;
    sum_in     = {dl_in[32], dl_in} + {dr_in[32], dr_in};
    diff_in    = {dr_in[32], dr_in} - {dl_in[32], dl_in};
    sum_mag_in = sum_in[33] ? 34'(-sum_in) : 34'(sum_in);
    diff_mag   = diff[33] ? 34'(-diff) : 34'(diff);
  end

  //--------------------------------------------------------------------------
  // Datapath around the shared units
  //--------------------------------------------------------------------------
  always_comb begin
    // ds = (R*(dL+dR) + 2^16) >> 17
    ds_prod = sum[33] ? -$signed(md_result[63:0]) : $signed(md_result[63:0]);
    ds_rnd  = ds_prod + 64'sd65536;
    // Q.32 heading change, two's complement on a negative numerator
    t32_c   = diff[33] ? -md_result[63:0] : md_result[63:0];
    // travel clamped to +-2^32 before the rotation
    if (ds > 35'sd4294967296) dsc = 35'sd4294967296;
    else if (ds < -35'sd4294967296) dsc = -35'sd4294967296;
    else dsc = ds;
    dsc_mag = dsc[34] ? 33'(-dsc) : 33'(dsc);
    ds_mag  = ds[34] ? 35'(-ds) : 35'(ds);
    cos_mag = cos_val[33] ? 34'(-cos_val) : 34'(cos_val);
    sin_mag = sin_val[33] ? 34'(-sin_val) : 34'(sin_val);
    // x uses cos, y uses sin; same rounding and saturation path
    trig     = (state == S_PY) ? sin_val : cos_val;
    acc_sel  = (state == S_PY) ? acc_y : acc_x;
    pos_prod = (dsc[34] ^ trig[33]) ? -$signed(md_result[63:0])
                                     : $signed(md_result[63:0]);
    pos_rnd  = 34'((pos_prod + 64'sd536870912) >>> 30);
    acc_sum  = {{4{acc_sel[31]}}, acc_sel} + {{2{pos_rnd[33]}}, pos_rnd};
    acc_new  = sat32(acc_sum);
    dth_big  = (dthq[49:43] != '0);
    cs_angle = (state == S_HBAM) ? heading + md_result[63:32]
                                 : {1'b0, heading[31:1]};
  end

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    md_ctl     = '{start: 1'b0, op: MD_MUL};
    md_a       = '0;
    md_b       = '0;
    cs_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = 66'(sum_mag_in);
          md_b       = {18'h0, radius};
          state_next = S_DS;
        end
      end
      S_DS: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = 66'(diff_mag);
          md_b       = {18'h0, radius};
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        // |num| << 16 over the track gives q and the Q.32 fraction at once
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_DIV};
          md_a       = {md_result[49:0], 16'h0};
          md_b       = {14'h0, track_eff};
          state_next = S_DTH;
        end
      end
      S_DTH: begin
        if (md_done) begin
          if (zero) begin
            cs_start   = 1'b1;
            state_next = S_QUAT;
          end else begin
            md_ctl     = '{start: 1'b1, op: MD_MUL};
            md_a       = {2'b00, t32_c};
            md_b       = {4'h0, TURN_SCALE};
            state_next = S_DBAM;
          end
        end
      end
      S_DBAM: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = {2'b00, 64'($signed(t32) >>> 1)};
          md_b       = {4'h0, TURN_SCALE};
          state_next = S_HBAM;
        end
      end
      S_HBAM: begin
        if (md_done) begin
          cs_start   = 1'b1;
          state_next = S_CS;
        end
      end
      S_CS: begin
        if (cs_done) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = 66'(dsc_mag);
          md_b       = cos_mag;
          state_next = S_PX;
        end
      end
      S_PX: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = 66'(dsc_mag);
          md_b       = sin_mag;
          state_next = S_PY;
        end
      end
      S_PY: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_MUL};
          md_a       = 66'(ds_mag);
          md_b       = {14'h0, USEC_PER_SEC};
          state_next = S_LVM;
        end
      end
      S_LVM: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_DIV};
          md_a       = md_result;
          md_b       = {10'h0, dt};
          state_next = S_LVD;
        end
      end
      S_LVD: begin
        if (md_done) begin
          if (dth_big) begin
            cs_start   = 1'b1;
            state_next = S_QUAT;
          end else begin
            md_ctl     = '{start: 1'b1, op: MD_MUL};
            md_a       = 66'(dthq);
            md_b       = {14'h0, USEC_PER_SEC};
            state_next = S_AVM;
          end
        end
      end
      S_AVM: begin
        if (md_done) begin
          md_ctl     = '{start: 1'b1, op: MD_DIV};
          md_a       = md_result;
          md_b       = {10'h0, dt};
          state_next = S_AVD;
        end
      end
      S_AVD: begin
        if (md_done) begin
          cs_start   = 1'b1;
          state_next = S_QUAT;
        end
      end
      S_QUAT: begin
        if (cs_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  //--------------------------------------------------------------------------
  // Pose state and output register
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left      <= '0;
      prev_right     <= '0;
      prev_left_bad  <= 1'b0;
      prev_right_bad <= 1'b0;
      acc_x          <= '0;
      acc_y          <= '0;
      heading        <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (accept) begin
        prev_left      <= cl;
        prev_right     <= cr;
        prev_left_bad  <= !lok;
        prev_right_bad <= !rok;
      end
      if (state == S_PX && md_done) acc_x <= acc_new;
      if (state == S_PY && md_done) begin
        acc_y   <= acc_new;
        heading <= heading + dbam;
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum  <= sum_in;
      diff <= diff_in;
      dt   <= dt_in;
      zero <= (dt_in == '0);
    end
    if (state == S_DS && md_done) ds <= 35'(ds_rnd >>> 17);
    if (state == S_DTH && md_done) begin
      t32  <= t32_c;
      dthq <= md_result[65:16];
      if (zero) begin
        lv <= '0;
        av <= '0;
      end
    end
    if (state == S_DBAM && md_done) dbam <= md_result[63:32];
    if (state == S_LVD && md_done) begin
      lv <= rate_of(ds[34], md_result);
      if (dth_big) av <= diff[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    if (state == S_AVD && md_done) av <= rate_of(diff[33], md_result);
    if (state == S_QUAT && cs_done) begin
      qz <= q15_of(sin_val);
      qw <= q15_of(cos_val);
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= {av, lv, qw, qz, heading, acc_y, acc_x};
      m_tuser <= zero;
    end
  end

  ddo_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .ctl    (md_ctl),
    .opa    (md_a),
    .opb    (md_b),
    .done   (md_done),
    .result (md_result)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cs_start),
    .angle   (cs_angle),
    .done    (cs_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

endmodule

@@ design/ddo_muldiv.sv @@
// ddo_muldiv: shared bit-serial unit, shift-add multiply and restoring divide.
// Depends on ddo_pkg.
module ddo_muldiv (
  input  logic            clk,
  input  logic            rst,
  input  ddo_pkg::md_ctl_t ctl,
  input  logic [65:0]     opa,    // multiplicand or dividend
  input  logic [33:0]     opb,    // multiplier, or divisor in the low 24 bits
  output logic            done,
  output logic [65:0]     result  // product mod 2^66 or quotient
);
  import ddo_pkg::*;

  localparam int DIV_STEPS = 66;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic             busy;
  md_op_t           op;
  logic [65:0]      ra;
  logic [65:0]      acc;
  logic [33:0]      rb;
  logic [23:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic             last;
  logic [24:0]      rsh;
  logic             fits;

  always_comb begin
    last = (op == MD_MUL) ? (rb == '0) : (cnt == '0);
    rsh  = {rem, ra[65]};
    fits = rsh >= {1'b0, rb[23:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op  <= ctl.op;
      ra  <= opa;
      rb  <= opb;
      acc <= '0;
      rem <= '0;
      cnt <= CNT_W'(DIV_STEPS);
    end else if (busy && !last) begin
      if (op == MD_MUL) begin
        if (rb[0]) acc <= acc + ra;
        ra <= ra << 1;
        rb <= rb >> 1;
      end else begin
        ra <= ra << 1;
        if (fits) rem <= 24'(rsh - {1'b0, rb[23:0]});
        else rem <= rsh[23:0];
        acc <= {acc[64:0], fits};
        cnt <= cnt - 1'b1;
      end
    end
  end

  assign result = acc;

endmodule

@@ design/ddo_cordic.sv @@
// ddo_cordic: iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddo_pkg (gain and arctangent table).
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,    // binary angle
  output logic               done,
  output logic signed [33:0] cos_val,  // Q.30, held until next start
  output logic signed [33:0] sin_val
);
  import ddo_pkg::*;

  localparam int CW = $clog2(STEPS + 1);

  logic               busy;
  logic               flip;
  logic signed [33:0] x, y, z;
  logic [CW-1:0]      i;
  logic               fold;
  logic [31:0]        a_f;
  logic signed [33:0] xs, ys, at;

  always_comb begin
    fold = (angle >= 32'h4000_0000) && (angle < 32'hC000_0000);
    a_f  = fold ? angle - 32'h8000_0000 : angle;
    xs   = x >>> i;
    ys   = y >>> i;
    at   = $signed({2'b00, atan_bam(5'(i))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (i == CW'(STEPS))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip <= fold;
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({{2{a_f[31]}}, a_f});
      i    <= '0;
    end else if (busy && (i != CW'(STEPS))) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
      i <= i + 1'b1;
    end
  end

  assign cos_val = flip ? -x : x;
  assign sin_val = flip ? -y : y;

endmodule

@@ test/odo_checker.sv @@
// odo_checker: watches the register port and both streams of diff_drive_odometry,
// predicts every pose transaction and compares it field by field.
// Depends on ddo_pkg.
`timescale 1ns / 100ps

module odo_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [87:0]  s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,
  input  logic [0:0]   m_tuser,
  output int           fail_count,
  output int           pending
);
  import ddo_pkg::*;

  typedef struct {
    logic [31:0] px, py, yaw;
    logic [15:0] qz, qw;
    logic [31:0] lv, av;
    logic        zt;
  } pose_t;

  localparam longint ATAN_TBL [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };
  localparam logic [63:0] RAD_TO_BAM = 64'd683565276;

  pose_t              pose_q [$];
  logic [15:0]        radius;
  logic [19:0]        track;
  logic [31:0]        last_l, last_r;
  logic               last_l_bad, last_r_bad;
  logic signed [31:0] x_acc, y_acc;
  logic [31:0]        yaw_acc;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // rotation-mode CORDIC on a binary angle, Q.30 results
  function automatic void sin_cos(input logic [31:0] a, output longint c,
                                  output longint s);
    bit     flip;
    longint x, y, z, nx;
    flip = 0;
    if (a >= 32'h40000000 && a < 32'hC0000000) begin
      a = a - 32'h80000000;
      flip = 1;
    end
    x = 652032874;
    y = 0;
    z = longint'($signed(a));
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TBL[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // value per second from a per-tick change, truncated toward zero
  function automatic longint per_second(longint v, logic [23:0] dt);
    bit     neg;
    longint mag, q;
    neg = v < 0;
    mag = neg ? -v : v;
    if (mag >= (64'sd1 <<< 43)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    q = (mag * 1000000) / longint'({40'b0, dt});
    if (q > 64'sd2147483648) q = 64'sd2147483648;
    return clamp32(neg ? -q : q);
  endfunction

  // advances the pose by one tick and returns the expected transaction
  function automatic pose_t odometry_step(logic [31:0] l, logic [31:0] r,
                                          logic lok, logic rok, logic [23:0] dt);
    longint      dl, dr, ds, num, mag, q, rem, dth16, lv, av, dsc, c, s, tr, rad;
    logic [63:0] t32, qu, ru, tu, th, prod;
    logic [31:0] dbam, hbam;
    bit          neg;
    pose_t       p;
    dl = 0;
    dr = 0;
    lv = 0;
    av = 0;
    rad = longint'({48'b0, radius});
    tr = (track == 0) ? 1 : longint'({44'b0, track});
    if (lok && !last_l_bad) dl = longint'($signed(l)) - longint'($signed(last_l));
    if (rok && !last_r_bad) dr = longint'($signed(r)) - longint'($signed(last_r));
    last_l = l;
    last_r = r;
    last_l_bad = !lok;
    last_r_bad = !rok;

    ds = ((dl + dr) * rad + 65536) >>> 17;
    num = (dr - dl) * rad;
    neg = num < 0;
    mag = neg ? -num : num;
    q = mag / tr;
    rem = mag % tr;
    dth16 = neg ? -q : q;
    qu = q;
    ru = rem;
    tu = tr;
    t32 = (qu << 16) + ((ru << 16) / tu);
    if (neg) t32 = -t32;

    if (dt != 0) begin
      prod = t32 * RAD_TO_BAM;
      dbam = prod[63:32];
      th = $unsigned($signed(t32) >>> 1);
      prod = th * RAD_TO_BAM;
      hbam = prod[63:32];
      dsc = ds;
      if (dsc > 64'sd4294967296) dsc = 64'sd4294967296;
      if (dsc < -64'sd4294967296) dsc = -64'sd4294967296;
      sin_cos(yaw_acc + hbam, c, s);
      x_acc = 32'(clamp32(longint'(x_acc) + ((dsc * c + 536870912) >>> 30)));
      y_acc = 32'(clamp32(longint'(y_acc) + ((dsc * s + 536870912) >>> 30)));
      yaw_acc = yaw_acc + dbam;
      lv = per_second(ds, dt);
      av = per_second(dth16, dt);
    end

    sin_cos(yaw_acc >> 1, c, s);
    p.px  = x_acc;
    p.py  = y_acc;
    p.yaw = yaw_acc;
    p.qz  = 16'(clamp16((s + 16384) >>> 15));
    p.qw  = 16'(clamp16((c + 16384) >>> 15));
    p.lv  = 32'(lv);
    p.av  = 32'(av);
    p.zt  = (dt == 0);
    return p;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    pose_t e;
    if (rst) begin
      radius = RADIUS_RST;
      track = TRACK_RST;
      last_l = '0;
      last_r = '0;
      last_l_bad = 0;
      last_r_bad = 0;
      x_acc = '0;
      y_acc = '0;
      yaw_acc = '0;
      pose_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (reg_idx_t'(paddr[2]) == REG_RADIUS) radius = pwdata[15:0];
        else if (reg_idx_t'(paddr[2]) == REG_TRACK) track = pwdata[19:0];
      end
      if (s_tvalid && s_tready)
        pose_q.push_back(odometry_step(s_tdata[31:0], s_tdata[63:32], s_tuser[0],
                                       s_tuser[1], s_tdata[87:64]));
      if (m_tvalid && m_tready) begin
        if (pose_q.size() == 0) begin
          $error("pose transaction with nothing expected");
          fail_count++;
        end else begin
          e = pose_q.pop_front();
          check_field("pos_x", e.px, m_tdata[31:0]);
          check_field("pos_y", e.py, m_tdata[63:32]);
          check_field("yaw_angle", e.yaw, m_tdata[95:64]);
          check_field("quat_z", {16'b0, e.qz}, {16'b0, m_tdata[111:96]});
          check_field("quat_w", {16'b0, e.qw}, {16'b0, m_tdata[127:112]});
          check_field("lin_vel", e.lv, m_tdata[159:128]);
          check_field("ang_vel", e.av, m_tdata[191:160]);
          check_field("zero_time", {31'b0, e.zt}, {31'b0, m_tuser[0]});
        end
      end
    end
    pending = pose_q.size();
  end

endmodule

@@ test/testbench.sv @@
// testbench: stimulus and verdict for diff_drive_odometry.
// Depends on ddo_pkg, the design and odo_checker.
`timescale 1ns / 100ps

module testbench;
  import ddo_pkg::*;

  logic         clk = 0;
  logic         rst = 1;
  logic         psel = 0, penable = 0, pwrite = 0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [87:0]  s_tdata = '0;   // left_angle, right_angle, elapsed_us
  logic [1:0]   s_tuser = '0;   // left_ok, right_ok
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [191:0] m_tdata;        // pos_x, pos_y, yaw_angle, quat_z, quat_w,
                                // lin_vel, ang_vel
  logic [0:0]   m_tuser;        // zero_time
  int           fail_count, pending;

  bit           no_gaps = 0;    // stretch with both sides always ready
  bit           hold_req = 0;   // asks the receiver for one long hold-off
  logic [31:0]  walk_l, walk_r; // current wheel angles of the random drive

  diff_drive_odometry i_dut (.*);

  odo_checker i_checker (.*);

  always #5 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random back-pressure, plus one long hold while the sender keeps going
  initial begin
    int  gap;
    bit  held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        gap = 3000;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // one tick transaction; returns at the falling edge after acceptance
  task automatic send_tick(logic [31:0] l, logic [31:0] r, logic lok, logic rok,
                           logic [23:0] dt);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {dt, r, l};
    s_tuser <= {rok, lok};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // sender pause until every pose transaction is back, then settle
  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // straight-line bursts with big steps push the position into saturation
  task automatic drive_burst();
    for (int i = 0; i < 6; i++) begin
      walk_l = walk_l + 32'h40000000;
      walk_r = walk_r + 32'h40000000;
      send_tick(walk_l, walk_r, 1, 1, 24'd1);
    end
  endtask

  // random drive: mostly plausible wheel motion, some noise and invalid angles
  task automatic random_ticks(int count);
    int          sel;
    logic [23:0] dt;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
        // pure noise
        walk_l = $urandom;
        walk_r = $urandom;
        send_tick(walk_l, walk_r, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  24'($urandom_range(0, 24'hFFFFFF)));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) dt = 24'($urandom_range(5000, 40000));
        else if (sel < 80) dt = 0;
        else if (sel < 90) dt = 24'($urandom_range(1, 100));
        else dt = 24'($urandom_range(0, 24'hFFFFFF));
        if ($urandom_range(0, 19) == 0) begin
          walk_l = walk_l + $urandom;
          walk_r = walk_r + $urandom;
        end else begin
          walk_l = walk_l + 32'($urandom_range(0, 40000)) - 32'd20000;
          walk_r = walk_r + 32'($urandom_range(0, 40000)) - 32'd20000;
        end
        send_tick(walk_l, walk_r, $urandom_range(0, 19) != 0,
                  $urandom_range(0, 19) != 0, dt);
      end
    end
  endtask

  // hard stop on the whole run
  initial begin
    #100_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [15:0] rad_set [6];
    logic [19:0] trk_set [6];
    rad_set = '{16'd6881, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd6881};
    trk_set = '{20'd34734, 20'd1, 20'd1048575, 20'd0, 20'd34734, 20'd34734};
    walk_l = '0;
    walk_r = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed ticks at reset settings
    send_tick(32'd0, 32'd0, 1, 1, 24'd20000);
    send_tick(32'h00010000, 32'h00010000, 1, 1, 24'd20000);    // straight ahead
    send_tick(32'h00010000, 32'h00030000, 1, 1, 24'd20000);    // left turn
    send_tick(32'h00000000, 32'h00040000, 1, 1, 24'd20000);    // spin in place
    send_tick(32'h00050000, 32'h00050000, 0, 1, 24'd20000);    // left invalid
    send_tick(32'h00060000, 32'h00060000, 1, 1, 24'd20000);    // tick after invalid
    send_tick(32'h00070000, 32'h00070000, 1, 0, 24'd20000);    // right invalid
    send_tick(32'h00080000, 32'h00080000, 0, 0, 24'd20000);    // both invalid
    send_tick(32'h00090000, 32'h00090000, 1, 1, 24'd20000);
    send_tick(32'h000A0000, 32'h000B0000, 1, 1, 24'd0);        // zero elapsed time
    send_tick(32'h000B0000, 32'h000D0000, 1, 1, 24'hFFFFFF);   // longest interval
    send_tick(32'h7FFFFFFF, 32'h80000000, 1, 1, 24'd1);        // huge opposite deltas
    send_tick(32'h80000000, 32'h7FFFFFFF, 1, 1, 24'd1);
    send_tick(32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1, 24'd1);
    send_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 24'd1);        // huge forward jump
    send_tick(32'h80000000, 32'h80000000, 1, 1, 24'd0);
    walk_l = 32'h80000000;
    walk_r = 32'h80000000;
    drive_burst();

    // register settings, extremes included
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      if (ph < 6) begin
        reg_write(REG_RADIUS, {16'b0, rad_set[ph]});
        reg_write(REG_TRACK, {12'b0, trk_set[ph]});
      end else begin
        reg_write(REG_RADIUS, $urandom_range(1, 65535));
        reg_write(REG_TRACK, $urandom_range(1, 20'hFFFFF));
      end
      drive_burst();
      no_gaps = (ph == 2);
      if (ph == 1) begin
        random_ticks(60);
        hold_req = 1;   // receiver stalls; sender keeps offering
        random_ticks(200);
      end else begin
        random_ticks(260);
      end
      no_gaps = 0;
    end

    drain();
    repeat (600) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
